// ===== rtl/hgk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgk_pkg
// Shared constants and types for the Hellschreiber glyph keyer.
// ----------------------------------------------------------------------------
package hgk_pkg;

  localparam int CHAR_W            = 8;
  localparam int GAP_W             = 5;
  localparam int ROM_ENTRIES       = 29;
  localparam int ROM_COLUMNS       = 5;
  localparam int GLYPH_COLUMNS_DEF = 5;
  localparam int GLYPH_ROWS_DEF    = 6;

  localparam logic [GAP_W-1:0]  GAP_RESET  = 5'd14;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

  // Classification of a looked-up character code
  typedef struct packed {
    logic glyph;  // code found in the glyph ROM
    logic space;  // code is a space: gap slots only
  } hgk_look_t;

endpackage

// ===== rtl/hgk_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgk_in_if
// Character channel: one character code per transaction.
// ----------------------------------------------------------------------------
interface hgk_in_if;
  import hgk_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);

endinterface

// ===== rtl/hgk_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgk_out_if
// Keying slot channel: one slot per transaction.
// ----------------------------------------------------------------------------
interface hgk_out_if;

  logic valid;
  logic ready;
  logic key_on;
  logic last;

  modport source (output valid, output key_on, output last, input ready);
  modport sink   (input valid, input key_on, input last, output ready);

endinterface

// ===== rtl/hgk_glyph_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgk_glyph_rom
// Glyph ROM with a registered read: code match, column bytes flattened into
// a slot pattern, first slot in the MSB.
// ----------------------------------------------------------------------------
module hgk_glyph_rom #(
  parameter int GLYPH_COLUMNS = hgk_pkg::GLYPH_COLUMNS_DEF,
  parameter int GLYPH_ROWS    = hgk_pkg::GLYPH_ROWS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [hgk_pkg::CHAR_W-1:0]             rd_code,
  output logic [GLYPH_COLUMNS*GLYPH_ROWS-1:0]    rd_bits,
  output hgk_pkg::hgk_look_t                     rd_look
);
  import hgk_pkg::*;

  localparam int SLOTS = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int ROM_W = ROM_COLUMNS * 8;

  localparam logic [CHAR_W-1:0] GLYPH_CODE [ROM_ENTRIES] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4C,
    8'h4D, 8'h4E, 8'h4F, 8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h2C
  };

  // Column 0 in the top byte
  localparam logic [ROM_W-1:0] GLYPH_COLS [ROM_ENTRIES] = '{
    40'h04047C0000, 40'h4864544C40, 40'h444454543C, 40'h1C10107C10,
    40'h405C545434, 40'h3C524A4830, 40'h4424140C04, 40'h6C5A545A6C,
    40'h084A4A2A38, 40'h3864544C38, 40'h782C242C78, 40'h447C545428,
    40'h386C444428, 40'h447C444438, 40'h7C54544444, 40'h386C445434,
    40'h7C1010107C, 40'h00447C4400, 40'h604040407C, 40'h7C40404040,
    40'h7C0810087C, 40'h7C0408107C, 40'h3844444438, 40'h5854545424,
    40'h04047C0404, 40'h7C4040407C, 40'h7C20100804, 40'h4428102844,
    40'h80A0600000
  };

  logic [ROM_W-1:0] hit_cols;
  logic             hit;
  logic [SLOTS-1:0] bits;
  hgk_look_t        look;

  always_comb begin
    int       csel;
    logic [7:0] col_byte;
    hit_cols = '0;
    hit      = 1'b0;
    // codes are unique, so OR-ing the matches selects one entry
    for (int i = 0; i < ROM_ENTRIES; i++) begin
      if (GLYPH_CODE[i] == rd_code) begin
        hit      = 1'b1;
        hit_cols = hit_cols | GLYPH_COLS[i];
      end
    end
    bits = '0;
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      csel     = (c < ROM_COLUMNS) ? c : 0;
      col_byte = hit_cols[(ROM_COLUMNS-1-csel)*8 +: 8];
      if (c >= ROM_COLUMNS) begin
        col_byte = 8'h00;
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        bits[SLOTS-1-(c*GLYPH_ROWS+r)] = col_byte[7-r];
      end
    end
    look.glyph = hit;
    look.space = (rd_code == SPACE_CODE);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bits <= bits;
      rd_look <= look;
    end
  end

endmodule

// ===== rtl/hell_glyph_keyer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hell_glyph_keyer
// Hellschreiber keyer: one character in, its keying slots out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one ASCII character code per transaction.
//   out_ch : one keying slot per transaction (key_on, last). A known glyph
//            gives GLYPH_COLUMNS*GLYPH_ROWS slots then gap_slots key-off
//            slots; a space gives only the gap slots; an unknown code gives
//            nothing. last marks the final slot of a character.
//   cfg_we / cfg_wdata : writes gap_slots; change it only while idle.
// Flow: a character accepted on in_ch is read from the glyph ROM, loaded
//   into the slot sequencer when it is free, and its slots then leave
//   through the output register.
// Throughput: one slot per cycle while out_ch.ready stays high; the slot
//   sequencer sets this. The next character is read while the current one
//   is still being sent and follows its last slot without a bubble.
// Reset: clears all control state and sets gap_slots to 14.
// Stall: while out_ch.ready is low the output register holds and the
//   sequencer waits; one pending character is held, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module hell_glyph_keyer #(
  parameter int GLYPH_COLUMNS = hgk_pkg::GLYPH_COLUMNS_DEF,
  parameter int GLYPH_ROWS    = hgk_pkg::GLYPH_ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  hgk_in_if.sink                    in_ch,
  hgk_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [hgk_pkg::GAP_W-1:0] cfg_wdata
);
  import hgk_pkg::*;

  localparam int SLOTS     = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int SLOT_CW   = $clog2(SLOTS + 1);

  logic [GAP_W-1:0]   gap_r;
  logic               pend_v_r, pend_v_nxt;
  logic               busy_r, busy_nxt;
  logic [SLOTS-1:0]   glyph_sr_r, glyph_sr_nxt;
  logic [SLOT_CW-1:0] glyph_left_r, glyph_left_nxt;
  logic [GAP_W-1:0]   gap_left_r, gap_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               key_r, key_nxt;
  logic               last_r, last_nxt;

  logic               in_fire;
  logic               in_ready;
  logic               out_free;
  logic               adv;
  logic               slot_last;
  logic               load;
  logic [SLOTS-1:0]   rd_bits;
  hgk_look_t          rd_look;

  assign in_fire = in_ch.valid && in_ready;

  hgk_glyph_rom #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_code (in_ch.char_code),
    .rd_bits (rd_bits),
    .rd_look (rd_look)
  );

  always_comb begin
    out_free  = !out_valid_r || out_ch.ready;
    adv       = busy_r && out_free;
    slot_last = (glyph_left_r == SLOT_CW'(1) && gap_left_r == '0) ||
                (glyph_left_r == '0 && gap_left_r == GAP_W'(1));
    // load the pending character when idle or as the current one ends its final slot
    load      = pend_v_r && (!busy_r || (adv && slot_last));
    in_ready  = !pend_v_r || load;

    pend_v_nxt     = pend_v_r;
    busy_nxt       = busy_r;
    glyph_sr_nxt   = glyph_sr_r;
    glyph_left_nxt = glyph_left_r;
    gap_left_nxt   = gap_left_r;
    out_valid_nxt  = out_valid_r;
    key_nxt        = key_r;
    last_nxt       = last_r;

    if (adv) begin
      out_valid_nxt = 1'b1;
      last_nxt      = slot_last;
      if (glyph_left_r != '0) begin
        key_nxt        = glyph_sr_r[SLOTS-1];
        glyph_sr_nxt   = glyph_sr_r << 1;
        glyph_left_nxt = glyph_left_r - SLOT_CW'(1);
      end else begin
        key_nxt      = 1'b0;
        gap_left_nxt = gap_left_r - GAP_W'(1);
      end
      if (slot_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      pend_v_nxt     = 1'b0;
      glyph_sr_nxt   = rd_bits;
      glyph_left_nxt = rd_look.glyph ? SLOT_CW'(SLOTS) : '0;
      gap_left_nxt   = gap_r;
      // unknown codes and a space with no gap produce no slots
      busy_nxt       = rd_look.glyph || (rd_look.space && gap_r != '0);
    end

    if (in_fire) begin
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= GAP_RESET;
      pend_v_r     <= 1'b0;
      busy_r       <= 1'b0;
      glyph_left_r <= '0;
      gap_left_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      pend_v_r     <= pend_v_nxt;
      busy_r       <= busy_nxt;
      glyph_left_r <= glyph_left_nxt;
      gap_left_r   <= gap_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_sr_r <= glyph_sr_nxt;
    key_r      <= key_nxt;
    last_r     <= last_nxt;
  end

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.key_on = key_r;
  assign out_ch.last   = last_r;

`ifndef SYNTH
  // a busy sequencer always has a slot left to send
  a_busy_has_slots: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (glyph_left_r != '0 || gap_left_r != '0))
    else $error("sequencer busy with no slots left");

  a_glyph_count: assert property (@(posedge clk) disable iff (!rst_n)
    glyph_left_r <= SLOT_CW'(SLOTS))
    else $error("glyph slot count out of range");

  // after a final slot the sequencer stays busy only through a fresh load
  a_end_of_char: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && slot_last) |=> (!busy_r || $past(load)))
    else $error("sequencer ran past the final slot");
`endif

endmodule
